// ===== hw/rtl/mnp_pkg.sv =====
// Package: shared constants, command/status types and helpers for the nearest-point store.
package mnp_pkg;

    localparam int MAX_CELLS = 131072;
    localparam int NUM_ORI   = 8;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int ORI_W     = $clog2(NUM_ORI);
    localparam int DIM_W     = 18;
    localparam int CRD_W     = DIM_W + 1;
    localparam int DIST_W    = 19;
    localparam int VOL_W     = 2 * DIM_W;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_DIM_Z = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 18'd32;

    typedef struct packed {
        logic load;
        logic ori;
        logic a1;
        logic a2;
        logic rd;
        logic upd;
        logic fold;
        logic set_any;
        logic emit;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic query;
        logic any;
        logic walk_more;
        logic o_last;
        logic clr_last;
        logic cfg_hit;
        logic out_free;
    } t_sts;

    function automatic logic [CRD_W-1:0] f_low_bit(input logic [CRD_W-1:0] v);
        return v & (~v + {{(CRD_W-1){1'b0}}, 1'b1});
    endfunction

endpackage

// ===== hw/rtl/mnp_req_if.sv =====
// Interface: request channel carrying one point word.
interface mnp_req_if;
    import mnp_pkg::*;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [DIM_W-1:0] x_coord;
    logic [DIM_W-1:0] y_coord;
    logic [DIM_W-1:0] z_coord;
    modport source (output valid, req_type, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, req_type, x_coord, y_coord, z_coord, output ready);
endinterface

// ===== hw/rtl/mnp_rsp_if.sv =====
// Interface: response channel carrying one distance word.
interface mnp_rsp_if;
    import mnp_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              found;
    modport source (output valid, distance, found, input ready);
    modport sink   (input valid, distance, found, output ready);
endinterface

// ===== hw/rtl/mnp_ram.sv =====
// Generic single-port RAM with registered read.
module mnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hw/rtl/mnp_ctrl.sv =====
// Controller: sequences clear pass, tree walks, folding and response.
module mnp_ctrl import mnp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_ORI, S_A1, S_A2, S_RD, S_UPD, S_FOLD, S_EMIT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.ok || (i_sts.query && !i_sts.any)) begin
                    n_state = i_sts.query ? S_EMIT : S_IDLE;
                end else begin
                    n_state = S_ORI;
                end
            end
            S_ORI: begin
                o_cmd.ori = 1'b1;
                n_state   = S_A1;
            end
            S_A1: begin
                o_cmd.a1 = 1'b1;
                n_state  = S_A2;
            end
            S_A2: begin
                o_cmd.a2 = 1'b1;
                n_state  = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.walk_more ? S_A1 : S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (i_sts.o_last) begin
                    if (i_sts.query) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.set_any = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    n_state = S_ORI;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // a dimension write restarts the clear pass
        if (i_sts.cfg_hit) n_state = S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== hw/rtl/mnp_dp.sv =====
// Datapath: dimension registers, walk counters, address math, banks and response register.
module mnp_dp import mnp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    mnp_req_if.sink          req,
    mnp_rsp_if.source        rsp,
    input  t_cmd             i_cmd,
    output t_sts             o_sts
);
    logic [DIM_W-1:0]  r_dim_x, r_dim_y, r_dim_z;
    logic [VOL_W-1:0]  r_vxy, r_vol;
    logic              r_vxy_ok;
    logic              r_req;
    logic [DIM_W-1:0]  r_x, r_y, r_z;
    logic [ORI_W-1:0]  r_o;
    logic [CRD_W-1:0]  r_my, r_mz, r_i, r_j, r_k;
    logic [DIST_W-1:0] r_sum, r_mxv, r_best;
    logic              r_have, r_any;
    logic [CELL_W-1:0] r_t, r_off, r_clr_addr;
    logic              r_out_valid, r_found;
    logic [DIST_W-1:0] r_dist;

    logic              cfg_hit, geo_ok;
    logic [DIM_W-1:0]  mx, my, mz;
    logic [CRD_W-1:0]  i_nx, j_nx, k_nx;
    logic              i_live, j_live, k_live;
    logic [DIST_W-1:0] rd_val, diff;
    logic [NUM_ORI-1:0]  bank_we;
    logic [CELL_W-1:0]   bank_addr;
    logic [DIST_W-1:0]   bank_wdata;
    logic [DIST_W-1:0]   bank_rdata [NUM_ORI];
    logic [2*CELL_W-1:0] prod_t, prod_o;

    assign cfg_hit = i_cfg_we && (i_cfg_idx == REG_DIM_X || i_cfg_idx == REG_DIM_Y
                                  || i_cfg_idx == REG_DIM_Z);

    assign geo_ok = (r_dim_x != '0) && (r_dim_y != '0) && (r_dim_z != '0) && r_vxy_ok
                    && (r_vol <= VOL_W'(MAX_CELLS));

    assign mx = r_o[0] ? r_dim_x - r_x + 1'b1 : r_x;
    assign my = r_o[1] ? r_dim_y - r_y + 1'b1 : r_y;
    assign mz = r_o[2] ? r_dim_z - r_z + 1'b1 : r_z;

    // up-walk for insert, down-walk for query
    assign i_nx   = r_req ? r_i - f_low_bit(r_i) : r_i + f_low_bit(r_i);
    assign j_nx   = r_req ? r_j - f_low_bit(r_j) : r_j + f_low_bit(r_j);
    assign k_nx   = r_req ? r_k - f_low_bit(r_k) : r_k + f_low_bit(r_k);
    assign i_live = r_req ? (i_nx != '0) : (i_nx <= {1'b0, r_dim_x});
    assign j_live = r_req ? (j_nx != '0) : (j_nx <= {1'b0, r_dim_y});
    assign k_live = r_req ? (k_nx != '0) : (k_nx <= {1'b0, r_dim_z});

    // offsets stay below MAX_CELLS, so low bits of each product suffice
    assign prod_t = CELL_W'(r_i - 1'b1) * r_dim_y[CELL_W-1:0];
    assign prod_o = r_t * r_dim_z[CELL_W-1:0];

    assign rd_val = bank_rdata[r_o];
    assign diff   = r_sum - r_mxv;

    always_comb begin
        bank_we    = '0;
        bank_addr  = i_cmd.clr ? r_clr_addr : r_off;
        bank_wdata = i_cmd.clr ? '0 : r_sum;
        if (i_cmd.clr) begin
            bank_we = '1;
        end else if (i_cmd.upd && !r_req && rd_val < r_sum) begin
            bank_we[r_o] = 1'b1;
        end
    end

    for (genvar g = 0; g < NUM_ORI; g++) begin : g_bank
        mnp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_CELLS)) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_addr  (bank_addr),
            .i_wdata (bank_wdata),
            .o_rdata (bank_rdata[g])
        );
    end

    always_comb begin
        o_sts.ok        = geo_ok && (r_x != '0) && (r_x <= r_dim_x) && (r_y != '0)
                          && (r_y <= r_dim_y) && (r_z != '0) && (r_z <= r_dim_z);
        o_sts.query     = r_req;
        o_sts.any       = r_any;
        o_sts.walk_more = i_live || j_live || k_live;
        o_sts.o_last    = (r_o == ORI_W'(NUM_ORI - 1));
        o_sts.clr_last  = (r_clr_addr == CELL_W'(MAX_CELLS - 1));
        o_sts.cfg_hit   = cfg_hit;
        o_sts.out_free  = !r_out_valid || rsp.ready;
    end

    assign rsp.valid    = r_out_valid;
    assign rsp.distance = r_dist;
    assign rsp.found    = r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x     <= DIM_RESET;
            r_dim_y     <= DIM_RESET;
            r_dim_z     <= DIM_RESET;
            r_any       <= 1'b0;
            r_have      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_o         <= '0;
        end else begin
            if (cfg_hit) begin
                unique case (i_cfg_idx)
                    REG_DIM_X: r_dim_x <= i_cfg_data;
                    REG_DIM_Y: r_dim_y <= i_cfg_data;
                    default:   r_dim_z <= i_cfg_data;
                endcase
                r_any      <= 1'b0;
                r_clr_addr <= '0;
            end else if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_o    <= '0;
                r_have <= 1'b0;
            end
            if (i_cmd.fold) begin
                r_o <= r_o + 1'b1;
                if (r_req && r_mxv != '0 && r_mxv <= r_sum && (!r_have || diff < r_best)) begin
                    r_have <= 1'b1;
                end
            end
            if (i_cmd.set_any) r_any <= 1'b1;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vxy    <= r_dim_x * r_dim_y;
        r_vxy_ok <= (r_vxy <= VOL_W'(MAX_CELLS));
        r_vol    <= r_vxy[DIM_W-1:0] * r_dim_z;
        if (i_cmd.load) begin
            r_req <= req.req_type;
            r_x   <= req.x_coord;
            r_y   <= req.y_coord;
            r_z   <= req.z_coord;
        end
        if (i_cmd.ori) begin
            r_my  <= {1'b0, my};
            r_mz  <= {1'b0, mz};
            r_i   <= {1'b0, mx};
            r_j   <= {1'b0, my};
            r_k   <= {1'b0, mz};
            r_sum <= DIST_W'({1'b0, mx}) + DIST_W'({1'b0, my}) + DIST_W'({1'b0, mz});
            r_mxv <= '0;
        end
        if (i_cmd.a1) r_t <= prod_t[CELL_W-1:0] + CELL_W'(r_j - 1'b1);
        if (i_cmd.a2) r_off <= prod_o[CELL_W-1:0] + CELL_W'(r_k - 1'b1);
        if (i_cmd.upd) begin
            if (r_req && rd_val > r_mxv) r_mxv <= rd_val;
            // advance k, carry into j, then i
            if (k_live) begin
                r_k <= k_nx;
            end else begin
                r_k <= r_mz;
                if (j_live) begin
                    r_j <= j_nx;
                end else begin
                    r_j <= r_my;
                    r_i <= i_nx;
                end
            end
        end
        if (i_cmd.fold && r_req && r_mxv != '0 && r_mxv <= r_sum
            && (!r_have || diff < r_best)) begin
            r_best <= diff;
        end
        if (i_cmd.emit) begin
            r_dist  <= r_have ? r_best : '0;
            r_found <= r_have;
        end
    end

`ifndef SYNTH
    a_one_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.clr |-> $countones(bank_we) <= 1)
        else $error("more than one bank written outside clear");
    a_have_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_have) |-> r_any)
        else $error("point found in empty store");
    a_ori_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fold && r_o != ORI_W'(NUM_ORI - 1)) |=> (r_o == $past(r_o) + 1'b1))
        else $error("orientation counter skipped");
    a_cfg_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (!r_any && r_clr_addr == '0))
        else $error("dimension write did not restart clear");
`endif
endmodule

// ===== hw/rtl/manhattan_nearest_point_3d.sv =====
// Top level: Manhattan nearest-point store over eight mirrored prefix-max Fenwick trees.
// Each word is handled alone. An insert or query is loaded and checked, then for each
// of the eight orientations the walk is set up and each visited tree node takes two
// address multiplies, a bank read and an update, the node count being the product of
// the three Fenwick walk lengths, at most (log2(dim)+1) per axis; each orientation ends
// with a fold. A query then loads its response word, waiting while the previous response
// is not taken. A rejected insert returns to idle after its check; a rejected query, or
// one on an empty store, goes straight to its response. The sequencer visits one node at
// a time on one bank port. After reset and after every dimension write, a clear pass over
// all 131072 entries (one entry of all eight banks a cycle) runs before the first word is
// taken. A query returns one response word; an insert returns none.
module manhattan_nearest_point_3d import mnp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mnp_req_if.sink          req,
    mnp_rsp_if.source        rsp,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data
);
    t_cmd w_cmd;
    t_sts w_sts;

    mnp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (req.valid),
        .o_in_ready (req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mnp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req        (req),
        .rsp        (rsp),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );
endmodule

// ===== dv/tb.sv =====
// Testbench for the Manhattan nearest-point store: directed corners, then random traffic.
module tb;
    import mnp_pkg::*;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 9000;      // longest insert at 32x32x32 plus margin
    localparam longint CYCLE_LIMIT = 8000000;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              found;
    } t_answer;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [DIM_W-1:0] i_cfg_data;

    mnp_req_if req_ch ();
    mnp_rsp_if rsp_ch ();

    manhattan_nearest_point_3d DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the block: dimensions and the set of stored points.
    logic [DIM_W-1:0] grid_x, grid_y, grid_z;
    t_point           stored_points[$];
    t_answer          pending_answers[$];

    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatch_count;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("manhattan_nearest_point_3d test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic fits_grid(input logic [DIM_W-1:0] x, input logic [DIM_W-1:0] y,
                                       input logic [DIM_W-1:0] z);
        longint volume;
        if (grid_x == 0 || grid_y == 0 || grid_z == 0)
            return 1'b0;
        volume = longint'(grid_x) * longint'(grid_y) * longint'(grid_z);
        if (volume > MAX_CELLS)
            return 1'b0;
        return x >= 1 && x <= grid_x && y >= 1 && y <= grid_y && z >= 1 && z <= grid_z;
    endfunction

    function automatic int abs_diff(input logic [DIM_W-1:0] a, input logic [DIM_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Apply one accepted word to the shadow and queue the answer it produces.
    task automatic predict_nearest(input logic kind, input t_point p);
        t_answer ans;
        int      best;
        int      gap;
        logic    ok;
        ok = fits_grid(p.x, p.y, p.z);
        if (kind == REQ_INSERT) begin
            if (ok)
                stored_points.push_back(p);
        end else begin
            ans = '0;
            if (ok && stored_points.size() > 0) begin
                best = 32'h7fffffff;
                foreach (stored_points[n]) begin
                    gap = abs_diff(p.x, stored_points[n].x) + abs_diff(p.y, stored_points[n].y)
                          + abs_diff(p.z, stored_points[n].z);
                    if (gap < best)
                        best = gap;
                end
                ans.distance = best[DIST_W-1:0];
                ans.found    = 1'b1;
            end
            pending_answers.push_back(ans);
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response: distance=%0d found=%0d",
                             rsp_ch.distance, rsp_ch.found);
            end else begin
                want = pending_answers.pop_front();
                if (rsp_ch.distance !== want.distance || rsp_ch.found !== want.found) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected distance=%0d found=%0d, got %0d %0d",
                                 want.distance, want.found, rsp_ch.distance, rsp_ch.found);
                end
            end
        end
    end

    // Send one word; valid stays high on return so back-to-back words need no toggle.
    task automatic send_word(input logic kind, input t_point p);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.x_coord  <= p.x;
        req_ch.y_coord  <= p.y;
        req_ch.z_coord  <= p.z;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_nearest(kind, p);
    endtask

    task automatic drain_and_settle();
        req_ch.valid <= 1'b0;
        while (pending_answers.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DIM_X: grid_x = value;
            REG_DIM_Y: grid_y = value;
            REG_DIM_Z: grid_z = value;
            default: ;
        endcase
        // Any dimension write wipes the store.
        if (idx != REG_SPARE)
            stored_points.delete();
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] dx, input logic [DIM_W-1:0] dy,
                            input logic [DIM_W-1:0] dz);
        drain_and_settle();
        write_reg(REG_DIM_X, dx);
        write_reg(REG_DIM_Y, dy);
        write_reg(REG_DIM_Z, dz);
    endtask

    function automatic t_point mk(input int x, input int y, input int z);
        t_point p;
        p.x = x[DIM_W-1:0];
        p.y = y[DIM_W-1:0];
        p.z = z[DIM_W-1:0];
        return p;
    endfunction

    function automatic logic [DIM_W-1:0] pick_coord(input logic [DIM_W-1:0] dim);
        int roll;
        roll = $urandom_range(99);
        if (roll < 88)
            return DIM_W'($urandom_range(int'(dim), 1));
        else if (roll < 92)
            return '0;
        else if (roll < 96)
            return dim + 1'b1;
        return DIM_W'($urandom);
    endfunction

    task automatic test_default_grid_corners();
        send_word(REQ_QUERY,  mk(1, 1, 1));          // empty store
        send_word(REQ_INSERT, mk(1, 1, 1));
        send_word(REQ_INSERT, mk(32, 32, 32));
        send_word(REQ_QUERY,  mk(1, 1, 1));
        send_word(REQ_QUERY,  mk(32, 32, 32));
        send_word(REQ_QUERY,  mk(16, 17, 5));
        send_word(REQ_INSERT, mk(1, 1, 1));          // repeat insert
        send_word(REQ_INSERT, mk(32, 1, 32));
        send_word(REQ_QUERY,  mk(31, 2, 30));
        send_word(REQ_INSERT, mk(0, 5, 5));          // out of range, dropped
        send_word(REQ_INSERT, mk(33, 5, 5));
        send_word(REQ_QUERY,  mk(5, 0, 5));
        send_word(REQ_QUERY,  mk(5, 5, 33));
        send_word(REQ_QUERY,  mk(262143, 262143, 262143));
        send_word(REQ_QUERY,  mk(1, 32, 1));
    endtask

    task automatic test_long_axis();
        set_grid(18'd1, 18'd1, 18'd131072);
        send_word(REQ_QUERY,  mk(1, 1, 7));
        send_word(REQ_INSERT, mk(1, 1, 131072));
        send_word(REQ_INSERT, mk(1, 1, 1));
        send_word(REQ_QUERY,  mk(1, 1, 65536));
        send_word(REQ_QUERY,  mk(1, 1, 131071));
        send_word(REQ_QUERY,  mk(1, 1, 131073));
        send_word(REQ_QUERY,  mk(2, 1, 5));
    endtask

    task automatic test_bad_geometry();
        // 131072 x 1 x 131072 overflows the cell budget.
        drain_and_settle();
        write_reg(REG_DIM_X, 18'd131072);
        send_word(REQ_INSERT, mk(1, 1, 1));
        send_word(REQ_QUERY,  mk(1, 1, 1));
        drain_and_settle();
        write_reg(REG_DIM_X, 18'd0);
        send_word(REQ_INSERT, mk(1, 1, 1));
        send_word(REQ_QUERY,  mk(1, 1, 1));
    endtask

    task automatic random_burst(input int count);
        t_point p;
        logic   kind;
        repeat (count) begin
            kind = ($urandom_range(99) < 50) ? REQ_QUERY : REQ_INSERT;
            p.x  = pick_coord(grid_x);
            p.y  = pick_coord(grid_y);
            p.z  = pick_coord(grid_z);
            send_word(kind, p);
        end
    endtask

    task automatic test_random_traffic();
        set_grid(18'd5, 18'd6, 18'd4);
        drain_and_settle();
        write_reg(REG_SPARE, 18'h3ffff);             // unknown index, no effect
        send_idle_pct = 36;
        recv_idle_pct = 51;
        random_burst(135);
        send_idle_pct = 51;
        recv_idle_pct = 36;
        random_burst(135);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_burst(135);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.x_coord  = '0;
        req_ch.y_coord  = '0;
        req_ch.z_coord  = '0;
        rsp_ch.ready    = 1'b0;
        grid_x          = DIM_RESET;
        grid_y          = DIM_RESET;
        grid_z          = DIM_RESET;
        send_idle_pct   = 36;
        recv_idle_pct   = 51;
        mismatch_count  = 0;
        cycle_count     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_grid_corners();
        test_long_axis();
        test_bad_geometry();
        test_random_traffic();
        drain_and_settle();

        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("manhattan_nearest_point_3d test passed");
        else
            $display("manhattan_nearest_point_3d test failed");
        $finish;
    end
endmodule
